// ===== src/mlfq_priority_statistics_top_assert.svh =====
// Assertion macros for the scheduler statistics unit.
// Used inside mlfq_priority_statistics_top; expects clk and rst_n in scope.
`ifndef MLFQ_PRIORITY_STATISTICS_TOP_ASSERT_SVH
`define MLFQ_PRIORITY_STATISTICS_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define MLFQPS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that implies another at the same edge.
`define MLFQPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another at the next edge.
`define MLFQPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mlfqps_pkg.sv =====
// Shared types and constants of the scheduler statistics unit.
// No dependencies; used by mlfq_priority_statistics_top.
`timescale 1ns / 1ps

package mlfqps_pkg;

  // Request kinds carried in the low bits of in_tuser.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_DECAY = 2'd1;
  localparam logic [1:0] REQ_PRIO  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PRI_MAX = 1'b0;
  localparam logic CFG_PRI_MIN = 1'b1;

  // Upper limit applied to the ready count before the load update.
  localparam logic [15:0] MAX_READY = 16'd255;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 104;

  typedef logic [1:0] req_t;

  // One result beat; cpu_use_out sits in the lowest bits.
  typedef struct packed {
    logic [31:0] cpu_use_x100;
    logic [31:0] load_avg_x100;
    logic [5:0]  priority_out;
    logic [31:0] cpu_use_out;
  } result_t;

endpackage

// ===== src/mlfq_priority_statistics_top.sv =====
// Scheduler statistics unit: load average, CPU usage decay and priority.
// Depends on mlfqps_pkg and mlfq_priority_statistics_top_assert.svh.
`timescale 1ns / 1ps

//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------
//  in_      | slave     | tuser: req_type, thread_is_idle
//           |           | tdata: ready_count, cpu_use_in, nice_in
//  out_     | master    | tdata: cpu_use_out, priority_out, load_avg_x100,
//           |           |        cpu_use_x100
//  cfg_     | write     | index 0 pri_max, index 1 pri_min
//
// One request is worked at a time by a small sequencer around a single shared
// 33x18 multiplier, a shared rounding shifter and a one-bit-per-cycle divider.
// A decay request is the longest, set by the restoring divider that forms the
// decay factor one bit per cycle. Load, priority and tick requests skip the
// divider, and an idle thread skips to the x100 scaling but for a load update.
// The finished result waits in an output register, so the next beat is taken
// while it is stalled. Reset (rst_n low, synchronous) clears the load average
// and sets pri_max to 63 and pri_min to 0.

module mlfq_priority_statistics_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] ready_count, [39:8] cpu_use_in, [45:40] nice_in, [47:46] zero
  input  logic [mlfqps_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] req_type, [2] thread_is_idle
  input  logic [mlfqps_pkg::IN_USER_W-1:0] in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] cpu_use_out, [37:32] priority_out, [69:38] load_avg_x100,
  // [101:70] cpu_use_x100, [103:102] zero
  output logic [mlfqps_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_addr,
  input  logic [5:0]                      cfg_wdata
);

  // Datapath widths. The multiplier takes a 33-bit signed operand (load
  // average, CPU usage or ready count) and an 18-bit signed constant or
  // decay factor; products and sums live in the product width.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int DEN_W   = 34;
  localparam int K_W     = FRAC_BITS;
  localparam int CNT_W   = $clog2(FRAC_BITS + 1);

  localparam longint ONE_FX = longint'(1) << FRAC_BITS;
  localparam longint C59    = (59 * ONE_FX) / 60;
  localparam longint C1     = ONE_FX / 60;

  localparam logic signed [MUL_B_W-1:0] C59_B  = MUL_B_W'(C59);
  localparam logic signed [MUL_B_W-1:0] C1_B   = MUL_B_W'(C1);
  localparam logic signed [MUL_B_W-1:0] C100_B = MUL_B_W'(100);
  localparam logic signed [ACC_W-1:0]   ONE_A  = ACC_W'(ONE_FX);
  localparam logic signed [ACC_W-1:0]   HALF_A = ACC_W'(ONE_FX / 2);
  localparam logic signed [ACC_W-1:0]   HALFM_A = ACC_W'(ONE_FX / 2 - 1);
  localparam logic signed [ACC_W-1:0]   ONEM_A = ACC_W'(ONE_FX - 1);
  localparam logic [DEN_W-1:0]          ONE_D  = DEN_W'(ONE_FX);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LA_MUL   = 4'd1;
  localparam logic [3:0] S_LA_N     = 4'd2;
  localparam logic [3:0] S_LA_SUM   = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_RC_MUL   = 4'd5;
  localparam logic [3:0] S_RC_TRN   = 4'd6;
  localparam logic [3:0] S_RC_ADD   = 4'd7;
  localparam logic [3:0] S_PR_QTR   = 4'd8;
  localparam logic [3:0] S_PR_RND   = 4'd9;
  localparam logic [3:0] S_PR_SUB   = 4'd10;
  localparam logic [3:0] S_PR_CLAMP = 4'd11;
  localparam logic [3:0] S_X_LA     = 4'd12;
  localparam logic [3:0] S_X_LA_RND = 4'd13;
  localparam logic [3:0] S_X_RC_RND = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] top;
    top = v[ACC_W-1:31];
    if ((&top) || (~|top)) begin
      return $signed(v[31:0]);
    end else if (v[ACC_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // Input beat fields.
  mlfqps_pkg::req_t   in_req;
  logic               in_idle;
  logic [7:0]         in_ready;
  logic signed [31:0] in_rc;
  logic signed [5:0]  in_nice;

  assign in_req   = in_tuser[1:0];
  assign in_idle  = in_tuser[2];
  assign in_ready = in_tdata[7:0];
  assign in_rc    = $signed(in_tdata[39:8]);
  assign in_nice  = $signed(in_tdata[45:40]);

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic signed [31:0] la_r, la_nxt;
  logic [5:0]       pri_max_r, pri_max_nxt;
  logic [5:0]       pri_min_r, pri_min_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Working registers of the current request.
  mlfqps_pkg::req_t   req_r, req_nxt;
  logic [8:0]         nready_r, nready_nxt;
  logic signed [5:0]  nice_r, nice_nxt;
  logic signed [31:0] rc_r, rc_nxt;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [K_W-1:0]     q_r, q_nxt;
  logic [5:0]         prio_r, prio_nxt;
  logic [31:0]        la100_r, la100_nxt;
  mlfqps_pkg::result_t out_data_r, out_data_nxt;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LA_MUL: begin
        mul_a = {la_r[31], la_r};
        mul_b = C59_B;
      end
      S_LA_N: begin
        mul_a = $signed({{(MUL_A_W-9){1'b0}}, nready_r});
        mul_b = C1_B;
      end
      S_RC_MUL: begin
        mul_a = {rc_r[31], rc_r};
        mul_b = $signed({{(MUL_B_W-K_W){1'b0}}, q_r});
      end
      S_X_LA: begin
        mul_a = {la_r[31], la_r};
        mul_b = C100_B;
      end
      S_X_LA_RND: begin
        mul_a = {rc_r[31], rc_r};
        mul_b = C100_B;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared scaler: divides by 2^FRAC_BITS, truncating toward zero or rounding
  // half away from zero, through one biased add and an arithmetic shift.
  logic signed [ACC_W-1:0] sc_in, sc_bias, sc_sum, sc_out;
  logic                    sc_round;

  assign sc_in    = (state_r == S_PR_RND) ? acc_r : prod_r;
  assign sc_round = (state_r == S_PR_RND) || (state_r == S_X_LA_RND) ||
                    (state_r == S_X_RC_RND);

  always_comb begin
    if (sc_round) begin
      sc_bias = sc_in[ACC_W-1] ? HALFM_A : HALF_A;
    end else begin
      sc_bias = sc_in[ACC_W-1] ? ONEM_A : '0;
    end
  end

  assign sc_sum = sc_in + sc_bias;
  assign sc_out = sc_sum >>> FRAC_BITS;

  // Restoring divider step for the decay factor 2la*F / (2la + F).
  logic [DEN_W-1:0] rem_sh, rem_sub;
  logic             rem_ge;

  assign rem_sh  = {rem_r[DEN_W-2:0], 1'b0};
  assign rem_ge  = (rem_sh >= den_r);
  assign rem_sub = rem_sh - den_r;

  // Sign-extended operands for the CPU usage and priority arithmetic.
  logic signed [ACC_W-1:0] nice_ext, rc_ext, pmax_ext, pmin_ext, rc_addend;
  logic signed [ACC_W-1:0] pr_lo;
  logic [5:0]              pr_clamped;
  logic [8:0]              in_n;
  logic [7:0]              ready_lim;

  assign nice_ext  = {{(ACC_W-6){nice_r[5]}}, nice_r};
  assign rc_ext    = {{(ACC_W-32){rc_r[31]}}, rc_r};
  assign pmax_ext  = $signed({{(ACC_W-6){1'b0}}, pri_max_r});
  assign pmin_ext  = $signed({{(ACC_W-6){1'b0}}, pri_min_r});
  assign rc_addend = (req_r == mlfqps_pkg::REQ_TICK) ? ONE_A : (nice_ext <<< FRAC_BITS);

  // Raise to pri_min first, then lower to pri_max, so crossed limits end at pri_max.
  assign pr_lo      = (acc_r < pmin_ext) ? pmin_ext : acc_r;
  assign pr_clamped = (pr_lo > pmax_ext) ? pri_max_r : pr_lo[5:0];

  assign ready_lim = ({8'd0, in_ready} > mlfqps_pkg::MAX_READY) ?
                     mlfqps_pkg::MAX_READY[7:0] : in_ready;
  assign in_n      = {1'b0, ready_lim} + {8'd0, ~in_idle};

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    la_nxt         = la_r;
    pri_max_nxt    = pri_max_r;
    pri_min_nxt    = pri_min_r;
    cnt_nxt        = cnt_r;
    req_nxt        = req_r;
    nready_nxt     = nready_r;
    nice_nxt       = nice_r;
    rc_nxt         = rc_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    q_nxt          = q_r;
    prio_nxt       = prio_r;
    la100_nxt      = la100_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      case (cfg_addr)
        mlfqps_pkg::CFG_PRI_MAX: pri_max_nxt = cfg_wdata;
        mlfqps_pkg::CFG_PRI_MIN: pri_min_nxt = cfg_wdata;
        default: pri_max_nxt = pri_max_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_req;
          nready_nxt = in_n;
          nice_nxt   = in_nice;
          rc_nxt     = in_rc;
          acc_nxt    = {{(ACC_W-32){in_rc[31]}}, in_rc};
          // The load average never goes negative, so 2la fits unsigned.
          rem_nxt    = {1'b0, la_r, 1'b0};
          den_nxt    = {1'b0, la_r, 1'b0} + ONE_D;
          q_nxt      = '0;
          cnt_nxt    = CNT_W'(FRAC_BITS);
          prio_nxt   = (in_idle && (in_req == mlfqps_pkg::REQ_DECAY ||
                                    in_req == mlfqps_pkg::REQ_PRIO)) ? pri_min_r : 6'd0;
          if (in_req == mlfqps_pkg::REQ_LOAD) begin
            state_nxt = S_LA_MUL;
          end else if (in_idle) begin
            state_nxt = S_X_LA;
          end else begin
            case (in_req)
              mlfqps_pkg::REQ_DECAY: state_nxt = S_DIV;
              mlfqps_pkg::REQ_PRIO:  state_nxt = S_PR_QTR;
              mlfqps_pkg::REQ_TICK:  state_nxt = S_RC_ADD;
              default:               state_nxt = S_LA_MUL;
            endcase
          end
        end
      end
      S_LA_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_LA_N;
      end
      S_LA_N: begin
        acc_nxt   = sc_out;
        prod_nxt  = mul_p;
        state_nxt = S_LA_SUM;
      end
      S_LA_SUM: begin
        la_nxt    = sat32(acc_r + prod_r);
        state_nxt = S_X_LA;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_sub : rem_sh;
        q_nxt   = {q_r[K_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_RC_MUL;
        end
      end
      S_RC_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_RC_TRN;
      end
      S_RC_TRN: begin
        acc_nxt   = sc_out;
        state_nxt = S_RC_ADD;
      end
      S_RC_ADD: begin
        rc_nxt    = sat32(acc_r + rc_addend);
        state_nxt = (req_r == mlfqps_pkg::REQ_TICK) ? S_X_LA : S_PR_QTR;
      end
      S_PR_QTR: begin
        // CPU usage / 4, truncated toward zero.
        acc_nxt   = (rc_ext + (rc_r[31] ? $signed(ACC_W'(3)) : $signed(ACC_W'(0)))) >>> 2;
        state_nxt = S_PR_RND;
      end
      S_PR_RND: begin
        acc_nxt   = sc_out;
        state_nxt = S_PR_SUB;
      end
      S_PR_SUB: begin
        acc_nxt   = pmax_ext - acc_r - (nice_ext <<< 1);
        state_nxt = S_PR_CLAMP;
      end
      S_PR_CLAMP: begin
        prio_nxt  = pr_clamped;
        state_nxt = S_X_LA;
      end
      S_X_LA: begin
        prod_nxt  = mul_p;
        state_nxt = S_X_LA_RND;
      end
      S_X_LA_RND: begin
        la100_nxt = sc_out[31:0];
        prod_nxt  = mul_p;
        state_nxt = S_X_RC_RND;
      end
      S_X_RC_RND: begin
        acc_nxt   = sc_out;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt.cpu_use_out   = rc_r;
          out_data_nxt.priority_out  = prio_r;
          out_data_nxt.load_avg_x100 = la100_r;
          out_data_nxt.cpu_use_x100  = acc_r[31:0];
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      la_r         <= '0;
      pri_max_r    <= 6'd63;
      pri_min_r    <= 6'd0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      la_r         <= la_nxt;
      pri_max_r    <= pri_max_nxt;
      pri_min_r    <= pri_min_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    nready_r   <= nready_nxt;
    nice_r     <= nice_nxt;
    rc_r       <= rc_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    prio_r     <= prio_nxt;
    la100_r    <= la100_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_data_r};

  // Checks on the sequencer and the load average.
  logic st_done, out_stall;

  assign st_done   = (state_r == S_DONE);
  assign out_stall = out_tvalid_r && !out_tready;

  `include "mlfq_priority_statistics_top_assert.svh"

  `MLFQPS_ASSERT_ALWAYS(a_la_nonneg, !la_r[31], "load average went negative")
  `MLFQPS_ASSERT_SAME(a_div_cnt, state_r == S_DIV, cnt_r != '0, "divider ran past its bits")
  `MLFQPS_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "beat taken, no work")
  `MLFQPS_ASSERT_NEXT(a_done_holds, st_done && out_stall, st_done, "stalled result lost")
  `MLFQPS_ASSERT_NEXT(a_prio_clamp, state_r == S_PR_CLAMP, prio_r <= pri_max_r, "prio too high")

endmodule

// ===== dv/mlfq_priority_statistics_top_test.sv =====
// Self-checking testbench for the scheduler statistics unit: load average,
// CPU usage decay, tick and priority requests checked against a local model.
// Depends on mlfqps_pkg and mlfq_priority_statistics_top.
`timescale 1ns / 1ps

module mlfq_priority_statistics_top_test;

  // Fixed point used by the block and by the local model (17.14 by default).
  localparam int     FRAC_BITS    = 14;
  localparam longint ONE_FX       = longint'(1) << FRAC_BITS;
  // Load update weights: 59/60 and 1/60 of one, both truncated.
  localparam longint LOAD_KEEP_FX = (59 * ONE_FX) / 60;
  localparam longint LOAD_GAIN_FX = ONE_FX / 60;
  localparam longint READY_CAP    = longint'(mlfqps_pkg::MAX_READY);

  // The run is far shorter than this even with every stall at its worst.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // The tail wait is longer than a decay request takes.
  localparam int TAIL_CYCLES   = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 270;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 50;

  // One request as the stimulus sees it, before it is packed onto the bus.
  typedef struct packed {
    mlfqps_pkg::req_t req;
    logic [7:0]       ready;
    logic             idle;
    logic [31:0]      rc;
    logic [5:0]       nice;
  } stats_req_t;

  // Keeps its own copy of the load average and the priority clamps, works out
  // the result of every accepted request and compares the results in order.
  class sched_stats_checker;
    longint              load_avg_fx;
    logic [5:0]          prio_ceiling;
    logic [5:0]          prio_floor;
    mlfqps_pkg::result_t pending_stats[$];
    int                  errors;

    function new();
      load_avg_fx  = 0;
      prio_ceiling = 6'd63;
      prio_floor   = 6'd0;
      errors       = 0;
    endfunction

    function void write_register(logic idx, logic [5:0] val);
      if (idx == mlfqps_pkg::CFG_PRI_MAX) begin
        prio_ceiling = val;
      end else begin
        prio_floor = val;
      end
    endfunction

    function longint saturate_word(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (v < -longint'(32'sh7FFF_FFFF) - 1) return -longint'(32'sh7FFF_FFFF) - 1;
      return v;
    endfunction

    // Round to the nearest integer, ties away from zero.
    function longint round_to_int(longint x);
      if (x >= 0) return (x + ONE_FX / 2) / ONE_FX;
      return (x - ONE_FX / 2) / ONE_FX;
    endfunction

    // The floor is applied first, so crossed clamps end at the ceiling.
    function logic [5:0] clamp_priority(longint rc, longint nice);
      longint p;
      p = longint'(prio_ceiling) - round_to_int(rc / 4) - 2 * nice;
      if (p < longint'(prio_floor)) p = longint'(prio_floor);
      if (p > longint'(prio_ceiling)) p = longint'(prio_ceiling);
      return p[5:0];
    endfunction

    function void accept_request(stats_req_t r);
      longint              rc;
      longint              nice;
      longint              twice_la;
      longint              den;
      longint              factor;
      longint              n;
      longint              la_x100;
      longint              rc_x100;
      logic [5:0]          prio;
      mlfqps_pkg::result_t res;
      rc   = longint'($signed(r.rc));
      nice = longint'($signed(r.nice));
      prio = 6'd0;
      if (r.req == mlfqps_pkg::REQ_LOAD) begin
        n = longint'(r.ready);
        if (n > READY_CAP) n = READY_CAP;
        if (!r.idle) n = n + 1;
        load_avg_fx = saturate_word((LOAD_KEEP_FX * load_avg_fx) / ONE_FX + LOAD_GAIN_FX * n);
      end else if (r.idle) begin
        // The idle thread keeps its CPU usage; only the tick leaves priority at zero.
        if (r.req != mlfqps_pkg::REQ_TICK) prio = prio_floor;
      end else if (r.req == mlfqps_pkg::REQ_DECAY) begin
        twice_la = 2 * load_avg_fx;
        den      = twice_la + ONE_FX;
        factor   = (den != 0) ? (twice_la * ONE_FX) / den : 0;
        rc       = saturate_word((factor * rc) / ONE_FX + nice * ONE_FX);
        prio     = clamp_priority(rc, nice);
      end else if (r.req == mlfqps_pkg::REQ_PRIO) begin
        prio = clamp_priority(rc, nice);
      end else begin
        rc = saturate_word(rc + ONE_FX);
      end
      la_x100 = round_to_int(load_avg_fx * 100);
      rc_x100 = round_to_int(rc * 100);
      res.cpu_use_out   = rc[31:0];
      res.priority_out  = prio;
      res.load_avg_x100 = la_x100[31:0];
      res.cpu_use_x100  = rc_x100[31:0];
      pending_stats.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    task check_result(mlfqps_pkg::result_t got);
      mlfqps_pkg::result_t want;
      if (pending_stats.size() == 0) begin
        report($sformatf("result beat %h with no request waiting", got));
        return;
      end
      want = pending_stats.pop_front();
      if (got.cpu_use_out !== want.cpu_use_out)
        report($sformatf("cpu_use_out %h, expected %h",
                         got.cpu_use_out, want.cpu_use_out));
      if (got.priority_out !== want.priority_out)
        report($sformatf("priority_out %0d, expected %0d",
                         got.priority_out, want.priority_out));
      if (got.load_avg_x100 !== want.load_avg_x100)
        report($sformatf("load_avg_x100 %0d, expected %0d",
                         $signed(got.load_avg_x100), $signed(want.load_avg_x100)));
      if (got.cpu_use_x100 !== want.cpu_use_x100)
        report($sformatf("cpu_use_x100 %0d, expected %0d",
                         $signed(got.cpu_use_x100), $signed(want.cpu_use_x100)));
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [mlfqps_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [mlfqps_pkg::IN_USER_W-1:0]  in_tuser;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [mlfqps_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                              cfg_we;
  logic [0:0]                        cfg_addr;
  logic [5:0]                        cfg_wdata;

  mlfqps_pkg::result_t out_beat;
  assign out_beat = out_tdata[$bits(mlfqps_pkg::result_t)-1:0];

  // Idle percentages of the two sides and the length of a long output hold.
  int unsigned source_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_cycles_left = 0;
  int unsigned cycle_count = 0;
  // Asked for by the stimulus; the hold itself starts once.
  logic        hold_req;
  logic        hold_started = 1'b0;

  sched_stats_checker sb = new();

  always #1 clk = ~clk;

  mlfq_priority_statistics_top #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // The receiver decides its ready at every falling edge. A long hold, when
  // one is asked for, is counted down here so that the sender keeps offering
  // beats until the block's output register and its working slot are full.
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started     <= 1'b1;
      out_tready       <= 1'b0;
      hold_cycles_left <= HOLD_CYCLES - 1;
    end else if (hold_cycles_left != 0) begin
      out_tready <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result beats are taken at the rising edge, before the block's own
  // registers move, and go straight to the checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_beat);
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mlfq_priority_statistics_top_test: done, errors");
      $finish;
    end
  end

  // Entered and left at a falling edge. The sender may idle for some cycles
  // first; the beat is then held until the block takes it, and the model
  // learns of the request at that same edge so that the order is kept.
  task automatic send_request(input stats_req_t r);
    while ($urandom_range(99) < source_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, r.nice, r.rc, r.ready};
    in_tuser  = {r.idle, r.req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accept_request(r);
    @(negedge clk);
  endtask

  task automatic send_fields(input mlfqps_pkg::req_t q, input logic [7:0] ready,
                             input logic idle, input logic [31:0] rc,
                             input logic [5:0] nice);
    stats_req_t r;
    r.req   = q;
    r.ready = ready;
    r.idle  = idle;
    r.rc    = rc;
    r.nice  = nice;
    send_request(r);
  endtask

  // Random request. CPU usage is drawn mostly from a range around zero, with
  // some full-range words, words close to the saturation ends and values on
  // the rounding ties of the priority.
  function automatic stats_req_t make_request();
    stats_req_t r;
    int         v;
    r.req  = 2'($urandom_range(3));
    r.idle = ($urandom_range(7) == 0);
    case ($urandom_range(3))
      0:       r.ready = 8'd0;
      1:       r.ready = 8'd255;
      2:       r.ready = 8'($urandom_range(8));
      default: r.ready = 8'($urandom_range(255));
    endcase
    case ($urandom_range(5))
      0:       r.rc = $urandom;
      1, 2:    r.rc = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      3:       r.rc = ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000) ^ $urandom_range(3);
      4:       r.rc = ($urandom_range(200) - 100) * 32'(2 * ONE_FX) + $urandom_range(2) - 1;
      default: r.rc = $urandom_range(32'h0010_0000);
    endcase
    if ($urandom_range(1)) begin
      v = $urandom_range(40) - 20;
    end else begin
      v = $urandom_range(63);
    end
    r.nice = v[5:0];
    return r;
  endfunction

  // Waits at rising edges until every expected result has come back.
  task automatic drain_results();
    while (sb.pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    sb.write_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Clamp settings for the random phases: all-zero, all-top, a normal window,
  // two crossed pairs (one at the extremes) and a narrow window.
  logic [5:0] phase_ceiling [RANDOM_PHASES] = '{6'd0, 6'd63, 6'd40, 6'd10, 6'd0, 6'd31};
  logic [5:0] phase_floor   [RANDOM_PHASES] = '{6'd0, 6'd63, 6'd10, 6'd40, 6'd63, 6'd5};

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = '0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    hold_req         = 1'b0;
    // The first phases idle the sender lightly and the receiver heavily.
    source_gap_pct   = 26;
    sink_stall_pct   = 51;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset clamps (63 down to 0). The load average
    // starts at zero, so the first decay has a zero factor.
    send_fields(mlfqps_pkg::REQ_LOAD,  8'd0,   1'b1, 32'd0,         6'd0);
    send_fields(mlfqps_pkg::REQ_DECAY, 8'd0,   1'b0, 32'h0001_0000, 6'd0);
    send_fields(mlfqps_pkg::REQ_LOAD,  8'd0,   1'b0, 32'd0,         6'd0);
    repeat (3) send_fields(mlfqps_pkg::REQ_LOAD, 8'd255, 1'b0, 32'h1234_5678, 6'd0);
    send_fields(mlfqps_pkg::REQ_LOAD,  8'd255, 1'b1, 32'hFFFF_FFFF, 6'h3F);
    // Decay at both ends of the CPU usage range, then nice at its usual limits.
    send_fields(mlfqps_pkg::REQ_DECAY, 8'hAA,  1'b0, 32'h7FFF_FFFF, 6'd31);
    send_fields(mlfqps_pkg::REQ_DECAY, 8'h55,  1'b0, 32'h8000_0000, 6'h20);
    send_fields(mlfqps_pkg::REQ_DECAY, 8'd0,   1'b0, 32'h0004_0000, 6'h2C);
    send_fields(mlfqps_pkg::REQ_DECAY, 8'd0,   1'b0, 32'hFFFC_0000, 6'd20);
    // Priority only: unclamped, clamped at the floor and at the ceiling,
    // and rc/4 exactly on a half, on both sides of zero.
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd0,   1'b0, 32'd0,         6'd0);
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd0,   1'b0, 32'h0100_0000, 6'd20);
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd0,   1'b0, 32'hF000_0000, 6'h20);
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd0,   1'b0, 32'h0000_8000, 6'd0);
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd0,   1'b0, 32'hFFFF_8000, 6'd0);
    // Tick: saturation at the top, the bottom end, and minus one to zero.
    send_fields(mlfqps_pkg::REQ_TICK,  8'd0,   1'b0, 32'h7FFF_FFFF, 6'd0);
    send_fields(mlfqps_pkg::REQ_TICK,  8'd0,   1'b0, 32'h8000_0000, 6'd0);
    send_fields(mlfqps_pkg::REQ_TICK,  8'd0,   1'b0, 32'hFFFF_C000, 6'd0);
    // The idle thread passes its CPU usage through for every request kind.
    send_fields(mlfqps_pkg::REQ_DECAY, 8'd3,   1'b1, 32'hDEAD_BEEF, 6'd5);
    send_fields(mlfqps_pkg::REQ_PRIO,  8'd3,   1'b1, 32'h0123_4567, 6'h30);
    send_fields(mlfqps_pkg::REQ_TICK,  8'd3,   1'b1, 32'h7FFF_FFFF, 6'd0);
    in_tvalid = 1'b0;

    // Random phases. Clamps change only once the block has returned every
    // result, since each request gives exactly one. The middle phases swap
    // the idle rates, the last ones run with no idling, and the first of
    // those starts with a long receiver hold.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      if (p == 2) begin
        source_gap_pct = 51;
        sink_stall_pct = 26;
      end else if (p == 4) begin
        source_gap_pct = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
      end
      write_register(mlfqps_pkg::CFG_PRI_MAX, phase_ceiling[p]);
      write_register(mlfqps_pkg::CFG_PRI_MIN, phase_floor[p]);
      repeat (PHASE_ITEMS) send_request(make_request());
      in_tvalid = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("mlfq_priority_statistics_top_test: done, clean");
    end else begin
      $display("mlfq_priority_statistics_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mlfqps_pkg.sv
src/mlfq_priority_statistics_top.sv
dv/mlfq_priority_statistics_top_test.sv
